// ===== rtl/bmalloc_pkg.sv =====
package bmalloc_pkg;

  // Store geometry
  localparam int BITMAP_BYTES = 1024;
  localparam int WORD_BYTES   = 8;
  localparam int WORD_BITS    = WORD_BYTES * 8;
  localparam int WORDS        = BITMAP_BYTES / WORD_BYTES;
  localparam int WADDR_W      = $clog2(WORDS);
  localparam int WCNT_W       = $clog2(WORDS + 1);
  localparam int BYTE_SEL_W   = $clog2(WORD_BYTES);
  localparam int BIT_SEL_W    = $clog2(WORD_BITS);

  // Field widths
  localparam int FUNC_W     = 2;
  localparam int NUM_W      = 14;
  localparam int STATUS_W   = 2;
  localparam int BYTES_W    = 11;
  localparam int LIM_W      = BYTES_W + 3;
  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W  = 1;

  localparam logic [BYTES_W-1:0] BYTES_RESET = BYTES_W'(1024);

  // Request codes
  localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_SET   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BYTES_IN_USE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_INDEX_BASE   = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE     = 4'b0001,
    ST_SCAN     = 4'b0010,
    ST_MARK_CHK = 4'b0100,
    ST_MARK_WR  = 4'b1000
  } state_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic mark_rd;
    logic mark_wr;
    logic emit_alloc;
    logic emit_range;
  } dp_cmd_t;

  typedef struct packed {
    logic found;
    logic scan_done;
    logic mark_bad;
  } dp_sts_t;

endpackage

// ===== rtl/bitmap_allocator.sv =====
// Bitmap allocator: a used/free map of BITMAP_BYTES bytes, one bit per item,
// bit n in byte n/8 at position n%8 (1 = used).
// Channels:
//   - command: an item is taken on a clock edge with start high and busy low.
//     in_func selects allocate lowest free, mark used or mark free;
//     in_item_number names the bit for mark requests.
//   - result: one item per command, shown for one cycle with out_valid high;
//     the receiver cannot hold it off, so the block never stalls on output.
//   - config: cfg_we writes cfg_data to register cfg_index (0 active bytes,
//     1 index base) on the same edge; write only while busy is low.
// Timing: the map lives in a memory of 64-bit words with one read and one
// write port. An allocate reads one word per cycle from word 0 up and
// stops at the first word with a free active bit or after the last active
// word; busy is already low while a result is shown. A mark request is a
// read-modify-write of one word; an out-of-range mark touches no word.
// Reset: config returns to 1024 active bytes and base 0, and a valid bit per
// word makes every word read as all free; no clearing pass is needed.
module bitmap_allocator (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [bmalloc_pkg::FUNC_W-1:0]     in_func,
  input  logic [bmalloc_pkg::NUM_W-1:0]      in_item_number,
  output logic                               out_valid,
  output logic [bmalloc_pkg::NUM_W-1:0]      out_result_number,
  output logic [bmalloc_pkg::STATUS_W-1:0]   out_status,
  input  logic                               cfg_we,
  input  logic [bmalloc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bmalloc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import bmalloc_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Sequence the request: scan words, or read-modify-write one word
  bmalloc_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .func  (in_func),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  // Hold the map, config and result registers
  bmalloc_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_func           (in_func),
    .in_item_number    (in_item_number),
    .cmd               (cmd),
    .sts               (sts),
    .out_valid         (out_valid),
    .out_result_number (out_result_number),
    .out_status        (out_status)
  );

endmodule

// ===== rtl/bmalloc_ctrl.sv =====
module bmalloc_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [bmalloc_pkg::FUNC_W-1:0] func,
  input  bmalloc_pkg::dp_sts_t         sts,
  output bmalloc_pkg::dp_cmd_t         cmd,
  output logic                         busy
);
  import bmalloc_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = (func == FUNC_ALLOC) ? ST_SCAN : ST_MARK_CHK;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.found || sts.scan_done) begin
          cmd.emit_alloc = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      ST_MARK_CHK: begin
        if (sts.mark_bad) begin
          cmd.emit_range = 1'b1;
          state_nxt      = ST_IDLE;
        end else begin
          cmd.mark_rd = 1'b1;
          state_nxt   = ST_MARK_WR;
        end
      end
      ST_MARK_WR: begin
        cmd.mark_wr = 1'b1;
        state_nxt   = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

endmodule

// ===== rtl/bmalloc_dp.sv =====
module bmalloc_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [bmalloc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bmalloc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [bmalloc_pkg::FUNC_W-1:0]     in_func,
  input  logic [bmalloc_pkg::NUM_W-1:0]      in_item_number,
  input  bmalloc_pkg::dp_cmd_t               cmd,
  output bmalloc_pkg::dp_sts_t               sts,
  output logic                               out_valid,
  output logic [bmalloc_pkg::NUM_W-1:0]      out_result_number,
  output logic [bmalloc_pkg::STATUS_W-1:0]   out_status
);
  import bmalloc_pkg::*;

  logic [BYTES_W-1:0]    bytes_in_use_r;
  logic                  index_base_r;
  logic [FUNC_W-1:0]     func_r;
  logic [NUM_W-1:0]      item_r;
  logic [WCNT_W-1:0]     cnt_r;
  logic                  chk_valid_r;
  logic [WADDR_W-1:0]    chk_addr_r;

  logic [WORD_BITS-1:0]  mem [WORDS];
  logic [WORDS-1:0]      valid_r;
  logic [WORD_BITS-1:0]  rd_data_r;
  logic                  rd_vld_r;

  logic                  out_valid_r;
  logic [NUM_W-1:0]      out_num_r;
  logic [STATUS_W-1:0]   out_status_r;

  logic [BYTES_W-1:0]    act_bytes;
  logic [BYTES_W:0]      round_up;
  logic [WCNT_W-1:0]     nwords;
  logic                  issue;
  logic [WORD_BITS-1:0]  word_eff;
  logic                  full_word;
  logic [WORD_BYTES-1:0] byte_open;
  logic [BYTE_SEL_W-1:0] sel_byte;
  logic [7:0]            sel_bits;
  logic [2:0]            sel_bit;
  logic [BIT_SEL_W-1:0]  pos;
  logic                  any_open;
  logic                  found;
  logic [NUM_W-1:0]      alloc_num;
  logic [NUM_W-1:0]      mark_bit;
  logic [WADDR_W-1:0]    mark_addr;
  logic [WORD_BITS-1:0]  mark_mask;
  logic [WORD_BITS-1:0]  mark_word;
  logic                  under;
  logic                  over;
  logic [WADDR_W-1:0]    rd_addr;
  logic                  wr_en;
  logic [WADDR_W-1:0]    wr_addr;
  logic [WORD_BITS-1:0]  wr_data;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_in_use_r <= BYTES_RESET;
      index_base_r   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BYTES_IN_USE: bytes_in_use_r <= BYTES_W'(cfg_data);
        REG_INDEX_BASE:   index_base_r   <= cfg_data[0];
        default:          ;
      endcase
    end
  end

  // Clamp the active size to the store and count the words to scan
  always_comb begin
    act_bytes = ({21'd0, bytes_in_use_r} > BITMAP_BYTES) ? BYTES_W'(BITMAP_BYTES)
                                                           : bytes_in_use_r;
    round_up  = {1'b0, act_bytes} + (BYTES_W+1)'(WORD_BYTES - 1);
    nwords    = WCNT_W'(round_up >> BYTE_SEL_W);
  end

  // Request latch
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= in_func;
      item_r <= in_item_number;
    end
  end

  // Scan address and check stage
  assign issue = cmd.scan && (cnt_r < nwords);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      chk_valid_r <= 1'b0;
    end else if (cmd.load) begin
      cnt_r       <= '0;
      chk_valid_r <= 1'b0;
    end else begin
      chk_valid_r <= issue;
      if (issue) begin
        cnt_r <= cnt_r + WCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    chk_addr_r <= cnt_r[WADDR_W-1:0];
  end

  // Word find: first byte that is active and not full, then its first zero bit
  always_comb begin
    word_eff  = rd_vld_r ? rd_data_r : '0;
    full_word = (BYTES_W'(chk_addr_r) < (act_bytes >> BYTE_SEL_W));
    for (int b = 0; b < WORD_BYTES; b++) begin
      byte_open[b] = (full_word || (BYTE_SEL_W'(b) < act_bytes[BYTE_SEL_W-1:0])) &&
                     (word_eff[b*8 +: 8] != 8'hFF);
    end
    any_open = |byte_open;
    sel_byte = '0;
    for (int b = WORD_BYTES - 1; b >= 0; b--) begin
      if (byte_open[b]) begin
        sel_byte = BYTE_SEL_W'(b);
      end
    end
    sel_bits = word_eff[{sel_byte, 3'b000} +: 8];
    sel_bit  = '0;
    for (int k = 7; k >= 0; k--) begin
      if (!sel_bits[k]) begin
        sel_bit = 3'(k);
      end
    end
    pos       = {sel_byte, sel_bit};
    found     = chk_valid_r && any_open;
    alloc_num = NUM_W'({chk_addr_r, pos}) + NUM_W'(index_base_r);
  end

  // Mark request decode
  always_comb begin
    under     = (item_r < NUM_W'(index_base_r));
    mark_bit  = item_r - NUM_W'(index_base_r);
    over      = ((LIM_W+1)'(mark_bit) >= (LIM_W+1)'({act_bytes, 3'b000}));
    mark_addr = mark_bit[BIT_SEL_W +: WADDR_W];
    mark_mask = WORD_BITS'(1) << mark_bit[BIT_SEL_W-1:0];
    mark_word = (func_r == FUNC_SET) ? (word_eff | mark_mask) : (word_eff & ~mark_mask);
  end

  assign sts.found     = found;
  assign sts.scan_done = (nwords == '0) ||
                         (chk_valid_r && !any_open &&
                          ((WCNT_W'(chk_addr_r) + WCNT_W'(1)) == nwords));
  assign sts.mark_bad  = ((func_r != FUNC_SET) && (func_r != FUNC_CLEAR)) || under || over;

  // Memory port control
  always_comb begin
    rd_addr = cmd.mark_rd ? mark_addr : cnt_r[WADDR_W-1:0];
    wr_en   = (cmd.scan && found) || cmd.mark_wr;
    wr_addr = cmd.mark_wr ? mark_addr : chk_addr_r;
    wr_data = cmd.mark_wr ? mark_word : (word_eff | (WORD_BITS'(1) << pos));
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  // A word never written reads as all free
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      rd_vld_r <= valid_r[rd_addr];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit_alloc || cmd.emit_range || cmd.mark_wr;
    end
  end

  always_ff @(posedge clk) begin
    priority if (cmd.emit_alloc) begin
      out_num_r    <= found ? alloc_num : '0;
      out_status_r <= found ? STAT_OK : STAT_FULL;
    end else if (cmd.emit_range) begin
      out_num_r    <= item_r;
      out_status_r <= STAT_RANGE;
    end else if (cmd.mark_wr) begin
      out_num_r    <= item_r;
      out_status_r <= STAT_OK;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_result_number = out_num_r;
  assign out_status        = out_status_r;

endmodule

// ===== rtl/bmalloc_chk.sv =====
module bmalloc_chk (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               start,
  input logic                               busy,
  input logic                               out_valid,
  input logic [bmalloc_pkg::NUM_W-1:0]      out_result_number,
  input logic [bmalloc_pkg::STATUS_W-1:0]   out_status
);
  import bmalloc_pkg::*;

  // An accepted item keeps the block busy on the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  // Finishing an item always presents its result
  a_done_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("busy dropped without a result");

  // One result per item: never two strobes in a row
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("back-to-back result strobes");

  // Full map reports number zero, and no unused status code appears
  a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == STAT_FULL) |-> (out_result_number == '0))
    else $error("full status with nonzero number");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == STAT_OK || out_status == STAT_FULL ||
                   out_status == STAT_RANGE))
    else $error("unused status code");

endmodule

bind bitmap_allocator bmalloc_chk u_bmalloc_chk (.*);

// ===== tb/bitmap_allocator_test.sv =====
`timescale 1ns / 1ps

// Checks the bitmap allocator through its command, result and config ports.
// A behavioral copy of the used/free map predicts every reply, which is
// queued when the command is taken and compared against each out_valid
// strobe in arrival order. Directed tests cover the corners (empty and
// oversized active size, base 1, full map, unused request code, numbers past
// the active bits), and random phases then run mostly small maps with random
// sizes and bases so that allocate, mark and full conditions all recur.
module bitmap_allocator_test;
  import bmalloc_pkg::*;

  // Code 3 has no meaning in the block; it must come back as out of range.
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam int RANDOM_PHASES = 14;
  localparam int PHASE_ITEMS   = 100;
  localparam int IDLE_PCT      = 31;
  // Wait that covers the worst allocate, which reads all 128 words.
  localparam int SCAN_CYCLES   = 135;

  typedef struct packed {
    logic [NUM_W-1:0]    number;
    logic [STATUS_W-1:0] status;
  } reply_t;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic [FUNC_W-1:0]     in_func;
  logic [NUM_W-1:0]      in_item_number;
  logic                  out_valid;
  logic [NUM_W-1:0]      out_result_number;
  logic [STATUS_W-1:0]   out_status;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Shadow copy of the map and the two registers.
  logic [7:0]         usage_map [BITMAP_BYTES];
  logic [BYTES_W-1:0] active_size;
  logic               number_base;

  reply_t pending_replies [$];
  int     errors;
  bit     steady;  // suppresses command idling for one long stretch

  bitmap_allocator DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_func           (in_func),
    .in_item_number    (in_item_number),
    .out_valid         (out_valid),
    .out_result_number (out_result_number),
    .out_status        (out_status),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run of about 1500 items.
  initial begin
    #10_000_000;
    $display("bitmap_allocator_test failed");
    $finish;
  end

  // Work out the reply to one request and update the shadow map.
  task automatic compute_reply(input logic [FUNC_W-1:0] func,
                               input logic [NUM_W-1:0] num, output reply_t r);
    int  act;
    int  i;
    int  pos;
    int  bitn;
    bit  found;
    act = (active_size > BITMAP_BYTES) ? BITMAP_BYTES : int'(active_size);
    found = 1'b0;
    r.number = num;
    r.status = STAT_RANGE;
    if (func == FUNC_ALLOC) begin
      // Scan bytes upward for the first one that is not all used.
      for (i = 0; i < act && !found; i++) begin
        if (usage_map[i] != 8'hFF) begin
          pos = 0;
          while (usage_map[i][pos]) pos++;
          usage_map[i][pos] = 1'b1;
          r.number = NUM_W'(i * 8 + pos + int'(number_base));
          r.status = STAT_OK;
          found = 1'b1;
        end
      end
      if (!found) begin
        r.number = '0;
        r.status = STAT_FULL;
      end
    end else if (func == FUNC_SET || func == FUNC_CLEAR) begin
      // Below the base or past the active bits: echo and leave the map alone.
      if (int'(num) >= int'(number_base) && int'(num) - int'(number_base) < act * 8) begin
        bitn = int'(num) - int'(number_base);
        usage_map[bitn / 8][bitn % 8] = (func == FUNC_SET);
        r.status = STAT_OK;
      end
    end
  endtask

  // Offer one item; hold it until the block takes it, then queue its reply.
  task automatic send_request(input logic [FUNC_W-1:0] func,
                              input logic [NUM_W-1:0] num);
    reply_t r;
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start          <= 1'b1;
    in_func        <= func;
    in_item_number <= num;
    do @(posedge clk); while (busy);
    compute_reply(func, num, r);
    pending_replies.push_back(r);
  endtask

  // Drop start and wait until every reply is in and the block is idle.
  task automatic drain;
    start <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    do @(posedge clk); while (busy);
    repeat (2) @(posedge clk);
  endtask

  // Write one register; only call this while the block is drained.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_BYTES_IN_USE) active_size = data;
    else number_base = data[0];
    @(posedge clk);
  endtask

  // Defaults after reset: 1024 bytes, base 0, all free.
  task automatic test_reset_defaults;
    send_request(FUNC_ALLOC, 14'h3FFF);
    send_request(FUNC_ALLOC, 14'h0000);
    send_request(FUNC_ALLOC, 14'h2AAA);
    send_request(FUNC_SET, 14'd8191);     // last active bit
    send_request(FUNC_SET, 14'd8192);     // one past the end
    send_request(FUNC_CLEAR, 14'h3FFF);   // widest number
    send_request(FUNC_UNUSED, 14'h3FFF);
    send_request(FUNC_CLEAR, 14'd1);
    send_request(FUNC_ALLOC, 14'h1555);   // refills the hole at bit 1
    drain();
  endtask

  // One byte with base 1: fill it, hit full, punch a hole, refill.
  task automatic test_full_small_map;
    write_reg(REG_BYTES_IN_USE, 11'd1);
    write_reg(REG_INDEX_BASE, 11'h7FF);
    repeat (9) send_request(FUNC_ALLOC, $urandom());
    send_request(FUNC_SET, 14'd0);        // below the base
    send_request(FUNC_CLEAR, 14'd8);      // last bit of the byte
    send_request(FUNC_ALLOC, 14'd0);
    send_request(FUNC_SET, 14'd9);        // past the active bits
    drain();
  endtask

  // Zero active bytes: nothing to scan, nothing addressable.
  task automatic test_empty_map;
    write_reg(REG_BYTES_IN_USE, 11'd0);
    write_reg(REG_INDEX_BASE, 11'd0);
    send_request(FUNC_ALLOC, 14'd0);
    send_request(FUNC_SET, 14'd0);
    drain();
  endtask

  // Active size above the store clamps to the store.
  task automatic test_oversized_map;
    write_reg(REG_BYTES_IN_USE, 11'h7FF);
    write_reg(REG_INDEX_BASE, 11'd1);
    send_request(FUNC_SET, 14'd8192);     // last bit with base 1
    send_request(FUNC_CLEAR, 14'd8193);   // past the store
    drain();
  endtask

  // Pick a mark number: mostly around the active range, some anywhere.
  function automatic logic [NUM_W-1:0] pick_number;
    int act;
    int lim;
    int r;
    act = (active_size > BITMAP_BYTES) ? BITMAP_BYTES : int'(active_size);
    lim = act * 8 + int'(number_base);
    r = $urandom_range(99);
    if (r < 75) return NUM_W'($urandom_range(lim + 1, 0));
    else if (r < 90) return NUM_W'($urandom());
    else return NUM_W'((lim > 0) ? lim - $urandom_range(1, 0) : 0);
  endfunction

  // Random phases: new size and base per phase, then a mixed request stream.
  task automatic test_random_traffic;
    logic [BYTES_W-1:0] size;
    int                 r;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: size = 11'h7FF;
        1: size = 11'd0;
        2: size = 11'd1;
        3: size = 11'd1024;
        default: begin
          r = $urandom_range(99);
          if (r < 70) size = BYTES_W'($urandom_range(12, 1));
          else if (r < 90) size = BYTES_W'($urandom_range(200, 13));
          else size = BYTES_W'($urandom_range(2047, 0));
        end
      endcase
      write_reg(REG_BYTES_IN_USE, size);
      write_reg(REG_INDEX_BASE, CFG_DATA_W'($urandom()));
      steady = (ph == 5);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        r = $urandom_range(99);
        if (r < 45) send_request(FUNC_ALLOC, NUM_W'($urandom()));
        else if (r < 65) send_request(FUNC_SET, pick_number());
        else if (r < 95) send_request(FUNC_CLEAR, pick_number());
        else send_request(FUNC_UNUSED, NUM_W'($urandom()));
      end
      drain();
    end
    steady = 1'b0;
  endtask

  // Compare each strobed reply with the oldest prediction.
  always @(posedge clk) begin : check_replies
    reply_t want;
    if (rst_n && out_valid) begin
      if (pending_replies.size() == 0) begin
        $display("%0t: unexpected reply number=%0d status=%0d", $time,
                 out_result_number, out_status);
        errors++;
      end else begin
        want = pending_replies.pop_front();
        if (out_result_number !== want.number) begin
          $display("%0t: result_number expected %0d actual %0d", $time,
                   want.number, out_result_number);
          errors++;
        end
        if (out_status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time,
                   want.status, out_status);
          errors++;
        end
      end
    end
  end

  initial begin
    errors         = 0;
    steady         = 1'b0;
    rst_n          = 1'b0;
    start          = 1'b0;
    in_func        = FUNC_ALLOC;
    in_item_number = '0;
    cfg_we         = 1'b0;
    cfg_index      = REG_BYTES_IN_USE;
    cfg_data       = '0;
    for (int i = 0; i < BITMAP_BYTES; i++) usage_map[i] = 8'h00;
    active_size = BYTES_RESET;
    number_base = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_full_small_map();
    test_empty_map();
    test_oversized_map();
    test_random_traffic();

    // Let any late strobe show up before the verdict.
    drain();
    repeat (SCAN_CYCLES) @(posedge clk);
    if (errors == 0 && pending_replies.size() == 0) begin
      $display("bitmap_allocator_test passed");
    end else begin
      $display("bitmap_allocator_test failed");
    end
    $finish;
  end

endmodule
